// ===== hw/rtl/agrf_pkg.sv =====
package agrf_pkg;

  // Gain format: unsigned Q1.GAIN_FRAC, step is signed Q.GAIN_FRAC
  localparam int GAIN_FRAC  = 24;
  localparam int GAIN_W     = GAIN_FRAC + 1;
  localparam int STEP_W     = GAIN_W + 1;
  localparam int Q16_SHIFT  = GAIN_FRAC - 16;

  // Sample and product widths
  localparam int SMP_W      = 16;
  localparam int MAG_W      = SMP_W + 1;
  localparam int PROD_W     = MAG_W + GAIN_W;
  localparam int SCL_W      = PROD_W - GAIN_FRAC;

  // Field widths
  localparam int OP_W       = 2;
  localparam int TGT_W      = 17;
  localparam int MS_W       = 16;
  localparam int RATE_W     = 18;
  localparam int CHAN_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RATE_W;

  // Frame count ms*rate/1000: drop 3 bits (1000 = 8 * 125), multiply by
  // ceil(2^38 / 125) and keep the bits from 38 up; exact over the full range
  localparam int MS_PER_S   = 1000;
  localparam int MS_RATE_W  = MS_W + RATE_W;
  localparam int RCP_PRE    = 3;
  localparam int FRM_NUM_W  = MS_RATE_W - RCP_PRE;
  localparam int RCP_W      = 32;
  localparam int RCP_SHIFT  = 38;
  localparam int FRM_PROD_W = FRM_NUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_125 = RCP_W'(64'd2199023256);

  // Divider widths: gain difference over frame count
  localparam int DIV_NUM_W  = GAIN_W;
  localparam int DIV_DEN_W  = GAIN_W;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

  // Constants
  localparam logic [TGT_W-1:0]     TGT_UNITY  = TGT_W'(65536);
  localparam logic [GAIN_W-1:0]    GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [SCL_W-1:0]     SAT_POS    = SCL_W'(32767);
  localparam logic [SCL_W-1:0]     SAT_NEG    = SCL_W'(32768);
  localparam logic [CHAN_W-1:0]    CHAN_MONO  = CHAN_W'(1);
  localparam logic [RATE_W-1:0]    RATE_RST   = RATE_W'(44100);
  localparam logic [CHAN_W-1:0]    CHAN_RST   = CHAN_W'(2);

  // Opcodes
  localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
  localparam logic [OP_W-1:0] OP_START = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] prod;
  } lane_res_t;

endpackage

// ===== hw/rtl/audio_gain_ramp_fader_unit.sv =====
// Channel  Ports                                         Handshake
// in       in_opcode/sample_left/sample_right/           in_valid, in_ready
//          target_gain/ramp_ms
// out      out_left, out_right, out_finished             out_valid, out_ready
// cfg      cfg_index, cfg_wdata                          cfg_we (no wait)
//
// A frame passes gain update, lane multiply and saturate into the output register;
// the next item is taken once the result is in that register. A ramp command with
// nonzero duration and sample rate holds the input through accept, frame count by
// reciprocal multiply, 25-step divide and hand-off; with a zero frame count it is
// freed after the frame count. Immediate commands do not hold the input. A stalled
// result holds the output register, one more frame waits in the lanes. Sync reset.
module audio_gain_ramp_fader_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [agrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [agrf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [agrf_pkg::OP_W-1:0]         in_opcode,
  input  logic [agrf_pkg::SMP_W-1:0]        in_sample_left,
  input  logic [agrf_pkg::SMP_W-1:0]        in_sample_right,
  input  logic [agrf_pkg::TGT_W-1:0]        in_target_gain,
  input  logic [agrf_pkg::MS_W-1:0]         in_ramp_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [agrf_pkg::SMP_W-1:0]        out_left,
  output logic [agrf_pkg::SMP_W-1:0]        out_right,
  output logic                              out_finished
);
  import agrf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_OUT  = 3'd2;
  localparam logic [2:0] ST_FRM  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [RATE_W-1:0] rate_r;
  logic [CHAN_W-1:0] chan_r;
  logic [GAIN_W-1:0] gain_now_r, gain_now_nxt;
  logic [GAIN_W-1:0] gain_tgt_r, gain_tgt_nxt;
  logic [STEP_W-1:0] gain_step_r, gain_step_nxt;
  logic              stopping_r, stopping_nxt;
  logic              finished_r, finished_nxt;
  logic              dir_up_r, dir_up_nxt;
  logic [SMP_W-1:0]  smp_l_r, smp_r_r;
  logic [FRM_NUM_W-1:0] frm_num_r;

  logic              accept;
  logic [TGT_W-1:0]  tgt_sat;
  logic [GAIN_W-1:0] tq;
  logic [MS_RATE_W-1:0] ms_rate;
  logic [FRM_PROD_W-1:0] frm_prod;
  logic [GAIN_W-1:0] frames;
  logic [GAIN_W-1:0] diff;
  logic              up;
  logic [GAIN_W+1:0] g_sum, g_tgt;
  logic              step_pos, step_neg, hit;
  logic [GAIN_W-1:0] g_adv;
  logic [STEP_W-1:0] s_adv;
  logic [GAIN_W-1:0] div_q;

  div_req_t          div_req;
  div_res_t          div_res;
  lane_res_t         lane_l, lane_r;
  logic              merge_ready;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Q16 target clipped to unity and widened to the gain format
  assign tgt_sat = (in_target_gain > TGT_UNITY) ? TGT_UNITY : in_target_gain;
  assign tq      = GAIN_W'(tgt_sat) << Q16_SHIFT;
  assign ms_rate = MS_RATE_W'(in_ramp_ms) * MS_RATE_W'(rate_r);

  // Frame count from the registered ms*rate/8
  assign frm_prod = FRM_PROD_W'(frm_num_r) * FRM_PROD_W'(RCP_125);
  assign frames   = frm_prod[RCP_SHIFT +: GAIN_W];

  // Frame gain advance with clamp at target
  assign g_sum    = {2'b00, gain_now_r} + {gain_step_r[STEP_W-1], gain_step_r};
  assign g_tgt    = {2'b00, gain_tgt_r};
  assign step_neg = gain_step_r[STEP_W-1];
  assign step_pos = !step_neg && (gain_step_r != '0);
  assign hit      = (step_pos && ($signed(g_sum) >= $signed(g_tgt))) ||
                    (step_neg && ($signed(g_sum) <= $signed(g_tgt)));
  assign g_adv    = (gain_step_r == '0) ? gain_now_r :
                    (hit ? gain_tgt_r : g_sum[GAIN_W-1:0]);
  assign s_adv    = hit ? '0 : gain_step_r;

  // Distance to target for the step divide
  assign up    = gain_tgt_r >= gain_now_r;
  assign diff  = up ? GAIN_W'(gain_tgt_r - gain_now_r) : GAIN_W'(gain_now_r - gain_tgt_r);
  assign div_q = div_res.quot;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    gain_now_nxt  = gain_now_r;
    gain_tgt_nxt  = gain_tgt_r;
    gain_step_nxt = gain_step_r;
    stopping_nxt  = stopping_r;
    finished_nxt  = finished_r;
    dir_up_nxt    = dir_up_r;
    div_req       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_FRAME: begin
              state_nxt = ST_MUL;
              if (!finished_r) begin
                gain_now_nxt  = g_adv;
                gain_step_nxt = s_adv;
                if (stopping_r && g_adv == '0 && s_adv == '0) begin
                  finished_nxt = 1'b1;
                end
              end
            end
            OP_SET, OP_STOP, OP_START: begin
              if (in_opcode != OP_SET || !stopping_r) begin
                gain_tgt_nxt  = (in_opcode == OP_STOP) ? '0 : tq;
                gain_step_nxt = '0;
                if (in_opcode == OP_STOP) begin
                  stopping_nxt = 1'b1;
                  if (in_ramp_ms == '0) begin
                    finished_nxt = 1'b1;
                  end
                end
                if (in_opcode == OP_START) begin
                  stopping_nxt = 1'b0;
                  finished_nxt = 1'b0;
                  gain_now_nxt = '0;
                end
                if (in_ramp_ms == '0 || rate_r == '0) begin
                  gain_now_nxt = (in_opcode == OP_STOP) ? '0 : tq;
                end else begin
                  state_nxt = ST_FRM;
                end
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (merge_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FRM: begin
        if (frames == '0) begin
          gain_now_nxt = gain_tgt_r;
          state_nxt    = ST_IDLE;
        end else begin
          dir_up_nxt       = up;
          div_req.start    = 1'b1;
          div_req.dividend = diff;
          div_req.divisor  = frames;
          state_nxt        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (div_q == '0) begin
            gain_now_nxt = gain_tgt_r;
          end else begin
            gain_step_nxt = dir_up_r ? STEP_W'(div_q) : STEP_W'(-STEP_W'(div_q));
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_r      <= RATE_RST;
      chan_r      <= CHAN_RST;
      gain_now_r  <= '0;
      gain_tgt_r  <= '0;
      gain_step_r <= '0;
      stopping_r  <= 1'b0;
      finished_r  <= 1'b0;
      dir_up_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gain_now_r  <= gain_now_nxt;
      gain_tgt_r  <= gain_tgt_nxt;
      gain_step_r <= gain_step_nxt;
      stopping_r  <= stopping_nxt;
      finished_r  <= finished_nxt;
      dir_up_r    <= dir_up_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_RATE:   rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_CHANNEL_COUNT: chan_r <= cfg_wdata[CHAN_W-1:0];
          default: begin
            rate_r <= rate_r;
          end
        endcase
      end
    end
  end

  // Frame samples: zeroed once finished, right zeroed in mono
  always_ff @(posedge clk) begin
    if (accept && in_opcode == OP_FRAME) begin
      smp_l_r <= finished_r ? '0 : in_sample_left;
      smp_r_r <= (finished_r || chan_r == CHAN_MONO) ? '0 : in_sample_right;
    end
  end

  // ms*rate with the low 3 bits dropped, for the frame count
  always_ff @(posedge clk) begin
    if (accept) begin
      frm_num_r <= ms_rate[MS_RATE_W-1:RCP_PRE];
    end
  end

  agrf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  agrf_lane u_lane_l (
    .clk    (clk),
    .load   (state_r == ST_MUL),
    .sample (smp_l_r),
    .gain   (gain_now_r),
    .res    (lane_l)
  );

  agrf_lane u_lane_r (
    .clk    (clk),
    .load   (state_r == ST_MUL),
    .sample (smp_r_r),
    .gain   (gain_now_r),
    .res    (lane_r)
  );

  agrf_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (state_r == ST_OUT && merge_ready),
    .lane_l       (lane_l),
    .lane_r       (lane_r),
    .fin          (finished_r),
    .ready        (merge_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left     (out_left),
    .out_right    (out_right),
    .out_finished (out_finished)
  );

  // Gain never exceeds unity
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_now_r <= GAIN_UNITY)
    else $error("gain above unity");

  // A live ramp step means the target is not yet reached
  a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
    gain_step_r != '0 |-> gain_now_r != gain_tgt_r)
    else $error("nonzero step at target");

  // A finished voice is a stopped voice at rest at zero gain
  a_fin_rest: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> (stopping_r && gain_now_r == '0 && gain_step_r == '0))
    else $error("finished voice not at rest");

endmodule

// ===== hw/rtl/agrf_div.sv =====
module agrf_div (
  input  logic                clk,
  input  logic                rst_n,
  input  agrf_pkg::div_req_t  req,
  output agrf_pkg::div_res_t  res
);
  import agrf_pkg::*;

  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      quo_nxt = {quo_r[DIV_NUM_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      den_r <= req.divisor;
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.quot = quo_r;

endmodule

// ===== hw/rtl/agrf_lane.sv =====
module agrf_lane (
  input  logic                          clk,
  input  logic                          load,
  input  logic [agrf_pkg::SMP_W-1:0]    sample,
  input  logic [agrf_pkg::GAIN_W-1:0]   gain,
  output agrf_pkg::lane_res_t           res
);
  import agrf_pkg::*;

  logic [MAG_W-1:0]  s_ext;
  logic [MAG_W-1:0]  mag;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;

  // Sign-magnitude split so the shift truncates toward zero
  assign s_ext = {sample[SMP_W-1], sample};
  assign mag   = s_ext[MAG_W-1] ? MAG_W'(~s_ext + MAG_W'(1)) : s_ext;

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r  <= sample[SMP_W-1];
      prod_r <= PROD_W'(mag) * PROD_W'(gain);
    end
  end

  assign res.neg  = neg_r;
  assign res.prod = prod_r;

endmodule

// ===== hw/rtl/agrf_merge.sv =====
module agrf_merge (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  agrf_pkg::lane_res_t            lane_l,
  input  agrf_pkg::lane_res_t            lane_r,
  input  logic                           fin,
  output logic                           ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [agrf_pkg::SMP_W-1:0]     out_left,
  output logic [agrf_pkg::SMP_W-1:0]     out_right,
  output logic                           out_finished
);
  import agrf_pkg::*;

  logic             valid_r;
  logic [SMP_W-1:0] left_r;
  logic [SMP_W-1:0] right_r;
  logic             fin_r;

  // Drop fraction bits, restore sign, clip to 16 bits
  function automatic logic [SMP_W-1:0] sat(input lane_res_t ln);
    logic [SCL_W-1:0] m;
    logic [SMP_W-1:0] v;
    m = ln.prod[PROD_W-1:GAIN_FRAC];
    if (ln.neg) begin
      v = (m > SAT_NEG) ? SAT_NEG[SMP_W-1:0] : SMP_W'(~m + SCL_W'(1));
    end else begin
      v = (m > SAT_POS) ? SAT_POS[SMP_W-1:0] : m[SMP_W-1:0];
    end
    return v;
  endfunction

  assign ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= sat(lane_l);
      right_r <= sat(lane_r);
      fin_r   <= fin;
    end
  end

  assign out_valid    = valid_r;
  assign out_left     = left_r;
  assign out_right    = right_r;
  assign out_finished = fin_r;

endmodule
